[design/mrw_pkg.sv]
// Shared constants for the Miller-Rabin witness test block.
// No dependencies.
`default_nettype none
package mrw_pkg;

	localparam int NUM_WIDTH = 62;
	localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

	typedef logic [NUM_WIDTH-1:0] num_t;
	typedef logic [1:0] verdict_t;

	localparam verdict_t VERDICT_NOT_PRIME = 2'd0;
	localparam verdict_t VERDICT_IS_TWO    = 2'd1;
	localparam verdict_t VERDICT_COMPOSITE = 2'd2;
	localparam verdict_t VERDICT_PASSES    = 2'd3;

endpackage
`default_nettype wire

[design/mrw_modmul.sv]
// Bit-serial shift-add modular multiplier: one multiplier bit per cycle.
// Depends on mrw_pkg.
`default_nettype none
module mrw_modmul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire mrw_pkg::num_t mul_p,
	input  wire mrw_pkg::num_t mul_q,
	input  wire mrw_pkg::num_t modulus,
	output logic               done,
	output mrw_pkg::num_t      product
);
	import mrw_pkg::*;

	logic                 running_q;
	num_t                 acc_q;
	num_t                 p_q;
	num_t                 q_q;
	logic [NUM_WIDTH:0]   sum;
	logic [NUM_WIDTH:0]   dbl;
	logic [NUM_WIDTH:0]   mod_ext;
	num_t                 sum_red;
	num_t                 dbl_red;

	always_comb begin
		mod_ext = {1'b0, modulus};
		sum     = {1'b0, acc_q} + {1'b0, p_q};
		dbl     = {p_q, 1'b0};
		sum_red = (sum >= mod_ext) ? NUM_WIDTH'(sum - mod_ext) : sum[NUM_WIDTH-1:0];
		dbl_red = (dbl >= mod_ext) ? NUM_WIDTH'(dbl - mod_ext) : dbl[NUM_WIDTH-1:0];
	end

	assign done    = running_q && (q_q == '0);
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
		end else if (start) begin
			running_q <= 1'b1;
		end else if (done) begin
			running_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			p_q   <= mul_p;
			q_q   <= mul_q;
		end else if (running_q && q_q != '0) begin
			if (q_q[0]) begin
				acc_q <= sum_red;
			end
			p_q <= dbl_red;
			q_q <= q_q >> 1;
		end
	end

endmodule
`default_nettype wire

[design/miller_rabin_witness_test_top.sv]
// Miller-Rabin witness test, top level: sequencer around one modular multiplier.
// Depends on mrw_pkg and mrw_modmul.
`default_nettype none
// One candidate and one base per word; start is taken while busy is low and
// the verdict comes with a one-cycle done strobe that cannot be held off.
// Trivial candidates (below two, two, even) answer in the cycle after start.
// Odd candidates first split off powers of two, then run each modular
// product through the single bit-serial multiplier: one base reduction,
// about 1.5 products per bit of d and one per squaring.
module miller_rabin_witness_test_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire mrw_pkg::num_t candidate,
	input  wire mrw_pkg::num_t witness_base,
	output mrw_pkg::verdict_t  verdict,
	output logic               done
);
	import mrw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_REDUCE,
		ST_POW,
		ST_POW_MUL,
		ST_POW_SQ,
		ST_SQR
	} state_t;

	state_t               state_q;
	num_t                 n_q;
	num_t                 a_q;
	num_t                 d_q;
	num_t                 acc_q;
	num_t                 base_q;
	num_t                 x_q;
	logic [CNT_WIDTH-1:0] r_q;
	logic                 mul_go_q;
	num_t                 op_p_q;
	num_t                 op_q_q;
	verdict_t             verdict_q;
	logic                 done_q;
	logic                 mul_done;
	num_t                 mul_prod;
	num_t                 n_minus1;

	mrw_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go_q),
		.mul_p   (op_p_q),
		.mul_q   (op_q_q),
		.modulus (n_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign n_minus1 = n_q - NUM_WIDTH'(1);
	assign busy     = (state_q != ST_IDLE);
	assign verdict  = verdict_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mul_go_q  <= 1'b0;
			done_q    <= 1'b0;
			verdict_q <= VERDICT_NOT_PRIME;
			n_q       <= '0;
			a_q       <= '0;
			d_q       <= '0;
			acc_q     <= '0;
			base_q    <= '0;
			x_q       <= '0;
			r_q       <= '0;
			op_p_q    <= '0;
			op_q_q    <= '0;
		end else begin
			mul_go_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q <= candidate;
						a_q <= witness_base;
						if (candidate < NUM_WIDTH'(2)) begin
							verdict_q <= VERDICT_NOT_PRIME;
							done_q    <= 1'b1;
						end else if (candidate == NUM_WIDTH'(2)) begin
							verdict_q <= VERDICT_IS_TWO;
							done_q    <= 1'b1;
						end else if (!candidate[0]) begin
							verdict_q <= VERDICT_NOT_PRIME;
							done_q    <= 1'b1;
						end else begin
							d_q     <= {candidate[NUM_WIDTH-1:1], 1'b0};
							r_q     <= '0;
							state_q <= ST_SPLIT;
						end
					end
				end
				ST_SPLIT: begin
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						r_q <= r_q + CNT_WIDTH'(1);
					end else begin
						// base mod n: sum of its set bits' powers of two mod n
						op_p_q   <= NUM_WIDTH'(1);
						op_q_q   <= a_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (mul_done) begin
						base_q  <= mul_prod;
						acc_q   <= NUM_WIDTH'(1);
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (d_q == '0) begin
						x_q      <= acc_q;
						op_p_q   <= acc_q;
						op_q_q   <= acc_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_SQR;
					end else if (d_q[0]) begin
						op_p_q   <= acc_q;
						op_q_q   <= base_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_POW_MUL;
					end else begin
						op_p_q   <= base_q;
						op_q_q   <= base_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_POW_SQ;
					end
				end
				ST_POW_MUL: begin
					if (mul_done) begin
						acc_q    <= mul_prod;
						op_p_q   <= base_q;
						op_q_q   <= base_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_POW_SQ;
					end
				end
				ST_POW_SQ: begin
					if (mul_done) begin
						base_q  <= mul_prod;
						d_q     <= d_q >> 1;
						state_q <= ST_POW;
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						if (mul_prod == NUM_WIDTH'(1) && x_q != NUM_WIDTH'(1)
								&& x_q != n_minus1) begin
							// nontrivial square root of one
							verdict_q <= VERDICT_COMPOSITE;
							done_q    <= 1'b1;
							state_q   <= ST_IDLE;
						end else if (r_q == CNT_WIDTH'(1)) begin
							verdict_q <= (mul_prod == NUM_WIDTH'(1)) ?
								VERDICT_PASSES : VERDICT_COMPOSITE;
							done_q    <= 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							x_q      <= mul_prod;
							r_q      <= r_q - CNT_WIDTH'(1);
							op_p_q   <= mul_prod;
							op_q_q   <= mul_prod;
							mul_go_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
